// ----- rtl/euclid_pkg.sv -----
// Shared types and constants for the Euclid greatest common divisor block.
// Used by euclid_alu, euclid_core and euclid_gcd_top; depends on nothing else.
package euclid_pkg;

   // Width of one operand on the stream ports and of the divisor result.
   localparam int unsigned FIELD_WIDTH = 32;
   // Request word: first_operand then second_operand, packed from bit 0.
   localparam int unsigned REQ_DATA_WIDTH = 2 * FIELD_WIDTH;

   // Flags produced by the shared compare and subtract unit.
   typedef struct packed {
      logic ge;    // minuend is greater than or equal to subtrahend
      logic zero;  // conditional difference is zero
   } alu_flags_type;

   // Status handed from the sequencer to the output stage.
   typedef struct packed {
      logic valid;      // a finished result is waiting
      logic both_zero;  // both operands were zero
   } core_status_type;

endpackage

// ----- rtl/euclid_alu.sv -----
// Shared compare and conditional subtract unit for the Euclid sequencer.
// Depends on euclid_pkg for the flag type.
module euclid_alu
   import euclid_pkg::*;
#(
   parameter int unsigned WIDTH = 33
) (
   input  logic [WIDTH-1:0] minuend,
   input  logic [WIDTH-1:0] subtrahend,
   output logic [WIDTH-1:0] result,
   output alu_flags_type    flags
);

   logic [WIDTH:0] diff;

   // The extra top bit is the borrow of the subtraction.
   assign diff        = {1'b0, minuend} - {1'b0, subtrahend};
   assign flags.ge    = ~diff[WIDTH];
   assign result      = flags.ge ? diff[WIDTH-1:0] : minuend;
   assign flags.zero  = (result == '0);

endmodule

// ----- rtl/euclid_core.sv -----
// Sequencer and operand registers of the Euclid remainder loop.
// Each remainder is taken by shifting the divisor up, then subtracting it back
// down one bit per cycle through euclid_alu. Depends on euclid_pkg.
module euclid_core
   import euclid_pkg::*;
#(
   parameter int unsigned OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] op_a,
   input  logic [OPERAND_WIDTH-1:0] op_b,
   input  logic                     take,
   output logic                     idle,
   output core_status_type          status,
   output logic [FIELD_WIDTH-1:0]   divisor
);

   localparam int unsigned CW = $clog2(OPERAND_WIDTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ALIGN  = 2'd1;
   localparam logic [1:0] ST_REDUCE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [OPERAND_WIDTH-1:0] x_ff, x_in;
   logic [OPERAND_WIDTH-1:0] d_ff, d_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     bz_ff, bz_in;

   logic [OPERAND_WIDTH:0]   alu_a, alu_b, alu_r;
   alu_flags_type            alu_f;
   logic [OPERAND_WIDTH-1:0] rem;
   logic [OPERAND_WIDTH+FIELD_WIDTH-1:0] div_ext;

   // In ALIGN the unit checks whether twice the divisor still fits below x;
   // in REDUCE it subtracts the divisor when it fits.
   assign alu_a = {1'b0, x_ff};
   assign alu_b = (state_ff == ST_ALIGN) ? {d_ff, 1'b0} : {1'b0, d_ff};

   euclid_alu #(
      .WIDTH (OPERAND_WIDTH + 1)
   ) u_alu (
      .minuend    (alu_a),
      .subtrahend (alu_b),
      .result     (alu_r),
      .flags      (alu_f)
   );

   assign rem = alu_r[OPERAND_WIDTH-1:0];

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      bz_in    = bz_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in   = op_a;
               cnt_in = '0;
               bz_in  = 1'b0;
               if (op_b == '0) begin
                  // A zero divisor ends at once with the other operand.
                  d_in     = op_a;
                  bz_in    = (op_a == '0);
                  state_in = ST_DONE;
               end else begin
                  d_in     = op_b;
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            if (alu_f.ge) begin
               d_in   = {d_ff[OPERAND_WIDTH-2:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (cnt_ff == '0) begin
               // Remainder complete: d holds the divisor when it is zero.
               if (alu_f.zero) begin
                  state_in = ST_DONE;
               end else begin
                  x_in     = d_ff;
                  d_in     = rem;
                  state_in = ST_ALIGN;
               end
            end else begin
               x_in   = rem;
               d_in   = {1'b0, d_ff[OPERAND_WIDTH-1:1]};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff   <= x_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      bz_ff  <= bz_in;
   end

   assign div_ext          = {{FIELD_WIDTH{1'b0}}, d_ff};
   assign divisor          = div_ext[FIELD_WIDTH-1:0];
   assign idle             = (state_ff == ST_IDLE);
   assign status.valid     = (state_ff == ST_DONE);
   assign status.both_zero = bz_ff;

endmodule

// ----- rtl/euclid_gcd_top.sv -----
// Euclid GCD top level: the core works on one item at a time; a zero second
// operand finishes in the cycle after it is taken, else each remainder step aligns
// the divisor and then reduces it bit by bit through the single shared compare and
// subtract unit. At best the next word is taken in the same cycle as the result
// reaches the output register. Synchronous active-high reset clears control.
// Depends on euclid_pkg, euclid_core and euclid_alu.
module euclid_gcd_top
   import euclid_pkg::*;
#(
   parameter int unsigned OPERAND_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0: first_operand[31:0], second_operand[63:32].
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0: divisor[31:0].
   output logic [FIELD_WIDTH-1:0]    rsp_tdata,
   // Fields from bit 0: both_zero[0].
   output logic                      rsp_tuser
);

   logic                     req_fire;
   logic                     core_idle;
   logic                     take;
   core_status_type          core_stat;
   logic [FIELD_WIDTH-1:0]   core_div;
   logic [OPERAND_WIDTH+FIELD_WIDTH-1:0] a_ext, b_ext;
   logic [OPERAND_WIDTH-1:0] op_a, op_b;

   logic                   out_valid_ff, out_valid_in;
   logic [FIELD_WIDTH-1:0] out_data_ff, out_data_in;
   logic                   out_bz_ff, out_bz_in;

   // Operands are cut to the working width, or zero-extended to it.
   assign a_ext = {{OPERAND_WIDTH{1'b0}}, req_tdata[FIELD_WIDTH-1:0]};
   assign b_ext = {{OPERAND_WIDTH{1'b0}}, req_tdata[REQ_DATA_WIDTH-1:FIELD_WIDTH]};
   assign op_a  = a_ext[OPERAND_WIDTH-1:0];
   assign op_b  = b_ext[OPERAND_WIDTH-1:0];

   assign req_tready = core_idle;
   assign req_fire   = req_tvalid & req_tready;

   euclid_core #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire),
      .op_a    (op_a),
      .op_b    (op_b),
      .take    (take),
      .idle    (core_idle),
      .status  (core_stat),
      .divisor (core_div)
   );

   // A finished result moves to the output register once that is free or draining.
   assign take = core_stat.valid & (~out_valid_ff | rsp_tready);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_bz_in    = out_bz_ff;
      if (take) begin
         out_valid_in = 1'b1;
         out_data_in  = core_div;
         out_bz_in    = core_stat.both_zero;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_bz_ff   <= out_bz_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_bz_ff;

   // The sequencer never offers to take a word while holding a result.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !core_stat.valid)
      else $error("request ready while a result is pending");

   // A zero second operand finishes in the very next cycle.
   a_zero_fast: assert property (@(posedge clock) disable iff (reset)
      (req_fire && op_b == '0) |=> core_stat.valid)
      else $error("zero divisor did not finish at once");

   // A pending result is held until the output stage takes it.
   a_core_hold: assert property (@(posedge clock) disable iff (reset)
      (core_stat.valid && !take) |=> (core_stat.valid && $stable(core_div)))
      else $error("pending result lost or changed");

   // The both-zero flag always comes with a zero divisor.
   a_bz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("both_zero with non-zero divisor");

endmodule
